@@ design/lsia_pkg.sv @@
// lsia_pkg: shared types and constants of the indexed-access LIFO stack.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package lsia_pkg;

  // Default build parameters
  localparam int DEPTH_DEF     = 256;
  localparam int WORD_BITS_DEF = 32;

  // Fixed field widths of the channels and the configuration register
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 9;
  localparam int DATA_W  = 32;
  localparam int LEVEL_W = 9;
  localparam int CAP_W   = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_PEEK   = 3'd2,
    KIND_IREAD  = 3'd3,
    KIND_SETTOP = 3'd4,
    KIND_IWRITE = 3'd5,
    KIND_FILL   = 3'd6
  } kind_t;

  // Memory access strobes from the controller to the entry store
  typedef struct packed {
    logic we;
    logic re;
  } mem_cmd_t;

endpackage

@@ design/lsia_if.sv @@
// lsia_if: valid/ready channel interfaces for operation words and result words.
// Depends on lsia_pkg for the field widths.
`timescale 1ns / 1ps

interface lsia_cmd_if import lsia_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   position;

  modport source (output valid, output kind, output value, output position, input ready);
  modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface lsia_res_if import lsia_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_data;
  logic [LEVEL_W-1:0] level;
  logic               is_empty;
  logic               is_full;
  logic               ignored;

  modport source (output valid, output read_data, output level, output is_empty,
                  output is_full, output ignored, input ready);
  modport sink   (input valid, input read_data, input level, input is_empty,
                  input is_full, input ignored, output ready);
endinterface

@@ design/lsia_mem.sv @@
// lsia_mem: single-port entry store, one shared address for writes and registered reads.
// Depends on lsia_pkg for the access strobe struct.
`timescale 1ns / 1ps

module lsia_mem import lsia_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                         clk,
  input  mem_cmd_t                     cmd,
  input  logic [$clog2(DEPTH)-1:0]     addr,
  input  logic [WORD_BITS-1:0]         wdata,
  output logic [WORD_BITS-1:0]         rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[addr] <= wdata;
    end
    if (cmd.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ design/lsia_ctrl.sv @@
// lsia_ctrl: operation sequencer of the stack: level, capacity, sweeps and result register.
// Depends on lsia_pkg, lsia_if; drives the access port of lsia_mem.
`timescale 1ns / 1ps

module lsia_ctrl import lsia_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  lsia_cmd_if.sink                   cmd,
  lsia_res_if.source                 res,
  input  logic                       cfg_we,
  input  logic [CAP_W-1:0]           cfg_data,
  output mem_cmd_t                   mem_cmd,
  output logic [$clog2(DEPTH)-1:0]   mem_addr,
  output logic [WORD_BITS-1:0]       mem_wdata,
  input  logic [WORD_BITS-1:0]       mem_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_EXEC
  } state_t;

  state_t               state;
  logic [CW-1:0]        level;
  logic [CW-1:0]        level_next;
  logic [CAP_W-1:0]     capacity;
  logic [AW-1:0]        sweep;
  logic [WORD_BITS-1:0] fill_word;
  logic                 pend_read;
  logic                 pend_ign;

  logic                 res_valid;
  logic [DATA_W-1:0]    res_data;
  logic [LEVEL_W-1:0]   res_level;
  logic                 res_empty;
  logic                 res_full;
  logic                 res_ign;

  logic [CW-1:0]        eff_cap;
  logic [WORD_BITS-1:0] word_in;
  logic [AW-1:0]        top_idx;
  logic [AW-1:0]        pos_idx;
  logic                 pos_ok;
  logic                 acc;
  logic                 acc_ign;
  logic                 res_free;

  // Clamp capacity to 1..DEPTH
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (32'(capacity) > DEPTH) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(capacity);
    end
  end

  assign word_in  = WORD_BITS'(cmd.value);
  assign top_idx  = (level == '0) ? '0 : AW'(level - CW'(1));
  assign pos_idx  = AW'(cmd.position - POS_W'(1));
  assign pos_ok   = (cmd.position != '0) && (32'(cmd.position) <= 32'(eff_cap));
  assign cmd.ready = (state == S_IDLE);
  assign acc      = cmd.valid && (state == S_IDLE);
  assign res_free = !res_valid || res.ready;

  // Memory access and level update for the current cycle
  always_comb begin
    mem_cmd    = '0;
    mem_addr   = sweep;
    mem_wdata  = '0;
    level_next = level;
    acc_ign    = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_cmd.we = 1'b1;
      end
      S_FILL: begin
        mem_cmd.we = 1'b1;
        mem_wdata  = fill_word;
      end
      S_IDLE: begin
        if (acc) begin
          mem_wdata = word_in;
          case (cmd.kind)
            KIND_PUSH: begin
              if (level < eff_cap) begin
                mem_cmd.we = 1'b1;
                mem_addr   = AW'(level);
                level_next = level + CW'(1);
              end else begin
                acc_ign = 1'b1;
              end
            end
            KIND_POP: begin
              mem_cmd.re = 1'b1;
              mem_addr   = top_idx;
              if (level != '0) begin
                level_next = level - CW'(1);
              end
            end
            KIND_PEEK: begin
              mem_cmd.re = 1'b1;
              mem_addr   = top_idx;
            end
            KIND_IREAD: begin
              mem_cmd.re = pos_ok;
              mem_addr   = pos_idx;
              acc_ign    = !pos_ok;
            end
            KIND_SETTOP: begin
              mem_cmd.we = 1'b1;
              mem_addr   = top_idx;
            end
            KIND_IWRITE: begin
              mem_cmd.we = pos_ok;
              mem_addr   = pos_idx;
              acc_ign    = !pos_ok;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      sweep     <= '0;
      level     <= '0;
      capacity  <= CAP_RESET;
      res_valid <= 1'b0;
      pend_read <= 1'b0;
      pend_ign  <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      level <= level_next;
      case (state)
        S_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            pend_read <= mem_cmd.re;
            pend_ign  <= acc_ign;
            fill_word <= word_in;
            sweep     <= '0;
            state     <= (cmd.kind == KIND_FILL) ? S_FILL : S_EXEC;
          end
        end
        S_FILL: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(eff_cap - CW'(1))) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // hold here while the previous result is still waiting
          if (res_free) begin
            res_valid <= 1'b1;
            res_data  <= pend_read ? DATA_W'(mem_rdata) : '0;
            res_level <= LEVEL_W'(level);
            res_empty <= (level == '0);
            res_full  <= (level >= eff_cap);
            res_ign   <= pend_ign;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid     = res_valid;
  assign res.read_data = res_data;
  assign res.level     = res_level;
  assign res.is_empty  = res_empty;
  assign res.is_full   = res_full;
  assign res.ignored   = res_ign;

endmodule

@@ design/lifo_stack_with_indexed_access_top.sv @@
// Bounded LIFO stack of words with push, pop, peek, set-top, indexed read/write and fill.
// After reset the store is cleared by a pass over all DEPTH entries, during which no operation
// word is accepted (capacity writes are taken). Each operation but fill then makes at most one
// access to the single-port entry memory: it is accepted in the idle state, and its result
// loads the output register in the exec state once that register is free. The result
// register lets the next operation be accepted while a result waits. Fill writes one entry
// per cycle over the effective capacity (capacity clamped to 1..DEPTH), then loads its result.
// Depends on lsia_pkg, lsia_if, lsia_mem and lsia_ctrl.
`timescale 1ns / 1ps

module lifo_stack_with_indexed_access_top import lsia_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  lsia_cmd_if.sink          cmd,
  lsia_res_if.source        res,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_data
);

  mem_cmd_t                 mem_cmd;
  logic [$clog2(DEPTH)-1:0] mem_addr;
  logic [WORD_BITS-1:0]     mem_wdata;
  logic [WORD_BITS-1:0]     mem_rdata;

  lsia_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  lsia_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

@@ design/lsia_checker.sv @@
// lsia_props: port-level checks of the LIFO stack, bound to the top level.
// Depends on lsia_pkg for the field widths.
`timescale 1ns / 1ps

module lsia_props import lsia_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [LEVEL_W-1:0] res_level,
  input logic               res_empty,
  input logic               res_full
);

  // No result word may appear right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word valid after reset");

  // One operation at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("operation accepted in back-to-back cycles");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_empty == (res_level == '0)))
    else $error("empty flag disagrees with level");

  // Capacity is at least one, so an empty stack never reads full
  a_not_empty_and_full: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_empty && res_full))
    else $error("result word both empty and full");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_level)))
    else $error("stalled result word changed");

endmodule

bind lifo_stack_with_indexed_access_top lsia_props u_lsia_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_level (res.level),
  .res_empty (res.is_empty),
  .res_full  (res.is_full)
);

@@ test/lsia_checker.sv @@
// lsia_checker: watches the operation and result channels of the indexed-access stack.
// Keeps its own copy of the stack and capacity and compares every result word by field.
// Depends on lsia_pkg and lsia_if.
`timescale 1ns / 1ps

module lsia_checker import lsia_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  lsia_cmd_if              cmd,
  lsia_res_if              res,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  output int               mismatches,
  output int               pending
);

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [LEVEL_W-1:0] level;
    logic               is_empty;
    logic               is_full;
    logic               ignored;
  } stack_status_t;

  logic [DATA_W-1:0] shadow_words [DEPTH_DEF];
  int                shadow_level;
  logic [CAP_W-1:0]  shadow_cap;
  stack_status_t     expected_status [$];
  int                err_count = 0;

  function automatic int usable_entries();
    if (shadow_cap == 0) return 1;
    if (shadow_cap > DEPTH_DEF) return DEPTH_DEF;
    return int'(shadow_cap);
  endfunction

  // Apply one operation to the shadow stack and return the status it should report
  function automatic stack_status_t apply_op(input logic [KIND_W-1:0]  kind,
                                             input logic [VALUE_W-1:0] word,
                                             input logic [POS_W-1:0]   pos);
    stack_status_t st;
    int            lim;
    int            slot;
    bit            pos_ok;
    lim    = usable_entries();
    st     = '0;
    slot   = int'(pos) - 1;
    pos_ok = (pos >= 1) && (int'(pos) <= lim);
    case (kind)
      KIND_PUSH: begin
        if (shadow_level < lim) begin
          shadow_words[shadow_level] = word;
          shadow_level++;
        end else begin
          st.ignored = 1'b1;
        end
      end
      KIND_POP: begin
        if (shadow_level > 0) begin
          shadow_level--;
          st.read_data = shadow_words[shadow_level];
        end else begin
          st.read_data = shadow_words[0];
        end
      end
      KIND_PEEK:   st.read_data = shadow_words[(shadow_level > 0) ? shadow_level - 1 : 0];
      KIND_IREAD: begin
        if (pos_ok) st.read_data = shadow_words[slot];
        else st.ignored = 1'b1;
      end
      // empty stack: set-top lands on the bottom entry
      KIND_SETTOP: shadow_words[(shadow_level > 0) ? shadow_level - 1 : 0] = word;
      KIND_IWRITE: begin
        if (pos_ok) shadow_words[slot] = word;
        else st.ignored = 1'b1;
      end
      KIND_FILL: begin
        for (int i = 0; i < lim; i++) shadow_words[i] = word;
      end
      default: ;
    endcase
    st.level    = shadow_level[LEVEL_W-1:0];
    st.is_empty = (shadow_level == 0);
    // level may sit above a lowered capacity; still full
    st.is_full  = (shadow_level >= lim);
    return st;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    stack_status_t want;
    if (rst) begin
      foreach (shadow_words[i]) shadow_words[i] = '0;
      shadow_level = 0;
      shadow_cap   = CAP_RESET;
      expected_status.delete();
    end else begin
      // results first: a word accepted this edge cannot answer this edge's operation
      if (res.valid && res.ready) begin
        if (expected_status.size() == 0) begin
          $error("result word with no operation outstanding");
          err_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("read_data", want.read_data, res.read_data);
          check_field("level", DATA_W'(want.level), DATA_W'(res.level));
          check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(res.is_empty));
          check_field("is_full", DATA_W'(want.is_full), DATA_W'(res.is_full));
          check_field("ignored", DATA_W'(want.ignored), DATA_W'(res.ignored));
        end
      end
      if (cmd.valid && cmd.ready)
        expected_status.push_back(apply_op(cmd.kind, cmd.value, cmd.position));
      if (cfg_we) shadow_cap = cfg_data;
    end
    pending    <= expected_status.size();
    mismatches <= err_count;
  end

endmodule

@@ test/tb_top.sv @@
// tb_top: stimulus for the indexed-access LIFO stack: directed corner cases, then
// random operation runs over a range of capacities. Checking is done by lsia_checker.
// Depends on lsia_pkg, lsia_if, lsia_checker and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import lsia_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam int                N_PHASES    = 10;

  typedef enum int {RUN_GROW, RUN_SHRINK, RUN_MIX} run_mode_e;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;
  int               mismatches;
  int               pending;

  int eff_cap    = DEPTH_DEF;
  int ops_sent   = 0;
  int cap_writes = 0;
  bit src_idle   = 1'b0;
  bit snk_idle   = 1'b0;
  bit quiet_tail = 1'b0;

  logic [CAP_W-1:0] phase_cap   [N_PHASES] = '{9'd0, 9'd511, 9'd256, 9'd1, 9'd2,
                                               9'd3, 9'd7, 9'd16, 9'd300, 9'd0};
  int               phase_items [N_PHASES] = '{100, 100, 500, 120, 150,
                                               150, 200, 250, 100, 80};

  lsia_cmd_if cmd_ch ();
  lsia_res_if res_ch ();

  lifo_stack_with_indexed_access_top dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  lsia_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  initial begin
    #25_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: random stalls while enabled
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (snk_idle && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] word,
                         input logic [POS_W-1:0] pos);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.kind     <= kind;
    cmd_ch.value    <= word;
    cmd_ch.position <= pos;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    ops_sent++;
  endtask

  // Hold off until every result is back, then let the block settle
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we   <= 1'b0;
    eff_cap  = (cap == 0) ? 1 : ((cap > DEPTH_DEF) ? DEPTH_DEF : int'(cap));
    cap_writes++;
  endtask

  function automatic logic [VALUE_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_position();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return POS_W'(eff_cap + 1);
      2:       return POS_W'($urandom_range(0, 511));
      default: return POS_W'($urandom_range(1, eff_cap));
    endcase
  endfunction

  // Runs that grow the stack to full, shrink it past empty, or mix every kind
  task automatic run_phase(input int n_items);
    int               left;
    int               run_len;
    run_mode_e        mode;
    logic [KIND_W-1:0] k;
    left = n_items;
    while (left > 0) begin
      mode    = run_mode_e'($urandom_range(0, 2));
      run_len = (mode == RUN_MIX) ? $urandom_range(1, 32) : eff_cap + $urandom_range(1, 6);
      if (run_len > left) run_len = left;
      if (!quiet_tail) begin
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle = ($urandom_range(0, 3) != 0);
      end
      repeat (run_len) begin
        case (mode)
          RUN_GROW: begin
            k = KIND_PUSH;
            if ($urandom_range(0, 9) == 0) k = KIND_W'($urandom_range(KIND_PEEK, KIND_IWRITE));
          end
          RUN_SHRINK: begin
            k = KIND_POP;
            if ($urandom_range(0, 9) == 0) k = KIND_W'($urandom_range(KIND_PEEK, KIND_IREAD));
          end
          default: k = KIND_W'($urandom_range(KIND_PUSH, KIND_UNUSED));
        endcase
        send_op(k, rand_word(), rand_position());
      end
      left -= run_len;
    end
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.kind     <= KIND_PUSH;
    cmd_ch.value    <= '0;
    cmd_ch.position <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-stack reads and set-top, full push, range limits, fill
    set_capacity(9'd4);
    send_op(KIND_POP, 32'h0, 9'd0);
    send_op(KIND_PEEK, 32'h0, 9'd0);
    send_op(KIND_SETTOP, 32'hFFFF_FFFF, 9'd0);
    send_op(KIND_PEEK, 32'h0, 9'd0);
    send_op(KIND_PUSH, 32'h0000_0000, 9'd0);
    send_op(KIND_PUSH, 32'hFFFF_FFFF, 9'd0);
    send_op(KIND_PUSH, 32'h1234_5678, 9'd0);
    send_op(KIND_PUSH, 32'h89AB_CDEF, 9'd0);
    send_op(KIND_PUSH, 32'hDEAD_BEEF, 9'd0);
    send_op(KIND_IREAD, 32'h0, 9'd0);
    send_op(KIND_IREAD, 32'h0, 9'd4);
    send_op(KIND_IREAD, 32'h0, 9'd5);
    send_op(KIND_IREAD, 32'h0, 9'd511);
    send_op(KIND_IWRITE, 32'h5555_AAAA, 9'd1);
    send_op(KIND_IWRITE, 32'h1111_1111, 9'd0);
    send_op(KIND_IWRITE, 32'h2222_2222, 9'd5);
    send_op(KIND_SETTOP, 32'h0F0F_0F0F, 9'd0);
    send_op(KIND_POP, 32'h0, 9'd0);
    send_op(KIND_UNUSED, 32'hFFFF_FFFF, 9'd511);
    send_op(KIND_FILL, 32'hA5A5_A5A5, 9'd0);
    send_op(KIND_IREAD, 32'h0, 9'd2);
    wait_idle();

    // Capacity dropped below the level: full, pushes dropped, pops still work
    set_capacity(9'd1);
    send_op(KIND_PUSH, 32'h7777_7777, 9'd0);
    send_op(KIND_POP, 32'h0, 9'd0);
    send_op(KIND_IREAD, 32'h0, 9'd1);
    send_op(KIND_PEEK, 32'h0, 9'd0);

    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      if (p == N_PHASES - 1) begin
        // last phase runs without any idling
        quiet_tail = 1'b1;
        src_idle   = 1'b0;
        snk_idle   = 1'b0;
        set_capacity(CAP_W'($urandom_range(4, 40)));
      end else begin
        set_capacity(phase_cap[p]);
      end
      run_phase(phase_items[p]);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Ran %0d stack operations under %0d capacity settings (0, 1, 256, 511 and others),",
             ops_sent, cap_writes);
    $display("covering full/empty edges, lowered capacity, range limits and fills.");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
